>>> rtl/bsg_pkg.sv
// shared types, register indexes, reset values and helpers for the bumper safety governor
// no dependencies

package bsg_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECAY_WEIGHT    = 3'd0,
        CFG_BACK_THRESHOLD  = 3'd1,
        CFG_FRONT_THRESHOLD = 3'd2,
        CFG_RECOVERY_SPEED  = 3'd3,
        CFG_DRIVE_TICKS     = 3'd4,
        CFG_PAUSE_TICKS     = 3'd5,
        CFG_TIMEOUT_TICKS   = 3'd6
    } t_cfg_idx;

    localparam logic [15:0]        RST_DECAY_WEIGHT    = 16'd55706;
    localparam logic [23:0]        RST_BACK_THRESHOLD  = 24'd122880;
    localparam logic [23:0]        RST_FRONT_THRESHOLD = 24'd138240;
    localparam logic signed [15:0] RST_RECOVERY_SPEED  = 16'sd410;
    localparam logic [7:0]         RST_DRIVE_TICKS     = 8'd6;
    localparam logic [7:0]         RST_PAUSE_TICKS     = 8'd5;
    localparam logic [7:0]         RST_TIMEOUT_TICKS   = 8'd5;

    localparam logic signed [15:0] SPEED_MIN = 16'sh8000;
    localparam logic signed [15:0] SPEED_MAX = 16'sh7FFF;

    typedef enum logic [1:0] {
        K_LEFT  = 2'd0,
        K_RIGHT = 2'd1,
        K_USER  = 2'd2,
        K_TICK  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_DRIVE = 2'd1,
        PH_PAUSE = 2'd2
    } t_phase;

    typedef struct packed {
        t_kind              kind;
        logic [15:0]        sample;
        logic signed [15:0] user_linear;
        logic signed [15:0] user_angular;
    } t_op;

    function automatic logic [7:0] sat_inc8(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

endpackage

>>> rtl/bsg_in_if.sv
// input channel: bumper samples, user velocity words and ticks
// no dependencies

interface bsg_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [15:0]        sample;
    logic signed [15:0] user_linear;
    logic signed [15:0] user_angular;

    modport source(output valid, command, sample, user_linear, user_angular, input ready);
    modport sink(input valid, command, sample, user_linear, user_angular, output ready);
endinterface

>>> rtl/bsg_out_if.sv
// output channel: one report word per tick
// no dependencies

interface bsg_out_if;
    logic               valid;
    logic               ready;
    logic [23:0]        average_left;
    logic [23:0]        average_right;
    logic               left_seen;
    logic               right_seen;
    logic               hit_report_valid;
    logic               front_bump;
    logic               back_bump;
    logic signed [15:0] safe_linear;
    logic signed [15:0] safe_angular;
    logic               recovering;

    modport source(output valid, average_left, average_right, left_seen, right_seen,
                   hit_report_valid, front_bump, back_bump, safe_linear, safe_angular,
                   recovering, input ready);
    modport sink(input valid, average_left, average_right, left_seen, right_seen,
                 hit_report_valid, front_bump, back_bump, safe_linear, safe_angular,
                 recovering, output ready);
endinterface

>>> rtl/bsg_front.sv
// front end: accepts input words, decodes the command and queues them
// depends on bsg_pkg and bsg_in_if

module bsg_front #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bsg_in_if.sink        i_item,
    output logic          o_q_valid,
    output bsg_pkg::t_op  o_q_op,
    input  logic          i_q_pop
);
    import bsg_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_op              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push;
    logic             w_pop;
    t_op              w_op;

    always_comb begin
        w_op.sample       = i_item.sample;
        w_op.user_linear  = i_item.user_linear;
        w_op.user_angular = i_item.user_angular;
        unique case (i_item.command)
            K_LEFT:  w_op.kind = K_LEFT;
            K_RIGHT: w_op.kind = K_RIGHT;
            K_USER:  w_op.kind = K_USER;
            default: w_op.kind = K_TICK;
        endcase
    end

    assign i_item.ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign w_push       = i_item.valid && i_item.ready;
    assign w_pop        = i_q_pop && (r_count != '0);
    assign o_q_valid    = (r_count != '0);
    assign o_q_op       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_op;
        end
    end

endmodule

>>> rtl/bsg_back.sv
// back end: averaging, recovery sequencing, command timeout and report register
// depends on bsg_pkg and bsg_out_if

module bsg_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_valid,
    input  bsg_pkg::t_op                     i_q_op,
    output logic                             o_q_pop,
    input  logic                             i_cfg_we,
    input  logic [bsg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bsg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    bsg_out_if.source                        o_result
);
    import bsg_pkg::*;

    // configuration
    logic [15:0]        r_decay;
    logic [23:0]        r_back_thr;
    logic [23:0]        r_front_thr;
    logic signed [15:0] r_speed;
    logic [7:0]         r_drive;
    logic [7:0]         r_pause;
    logic [7:0]         r_timeout;

    // state
    logic [23:0]        r_left_avg, n_left_avg;
    logic [23:0]        r_right_avg, n_right_avg;
    logic               r_left_seen, n_left_seen;
    logic               r_right_seen, n_right_seen;
    t_phase             r_phase, n_phase, w_tick_phase;
    logic               r_backward, n_backward;
    logic [7:0]         r_elapsed, n_elapsed;
    logic signed [15:0] r_held_lin, n_held_lin;
    logic signed [15:0] r_held_ang, n_held_ang;
    logic [7:0]         r_age, n_age;

    // report register
    logic               r_out_valid;
    logic [23:0]        r_out_avg_l;
    logic [23:0]        r_out_avg_r;
    logic               r_out_seen_l;
    logic               r_out_seen_r;
    logic               r_out_checked;
    logic               r_out_front;
    logic               r_out_back;
    logic signed [15:0] r_out_lin;
    logic signed [15:0] r_out_ang;
    logic               r_out_recov;

    logic               w_is_tick;
    logic               w_pop;
    logic [7:0]         w_inc_e;
    logic [7:0]         w_age_inc;
    logic               w_drive_cont;
    logic               w_pause_start;
    logic               w_pause_cont;
    logic               w_busy;
    logic               w_both;
    logic               w_front;
    logic               w_back;
    logic               w_hit;
    logic               w_stale;
    logic               w_pass;
    logic signed [15:0] w_rec_lin;
    logic signed [15:0] w_lin;
    logic signed [15:0] w_ang;

    // smoothing datapath
    logic [23:0]        w_old;
    logic               w_old_seen;
    logic [16:0]        w_new_wt;
    logic signed [24:0] w_diff;
    logic signed [42:0] w_prod;
    logic signed [42:0] w_round;
    logic [23:0]        w_smooth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay     <= RST_DECAY_WEIGHT;
            r_back_thr  <= RST_BACK_THRESHOLD;
            r_front_thr <= RST_FRONT_THRESHOLD;
            r_speed     <= RST_RECOVERY_SPEED;
            r_drive     <= RST_DRIVE_TICKS;
            r_pause     <= RST_PAUSE_TICKS;
            r_timeout   <= RST_TIMEOUT_TICKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DECAY_WEIGHT:    r_decay     <= i_cfg_data[15:0];
                CFG_BACK_THRESHOLD:  r_back_thr  <= i_cfg_data[23:0];
                CFG_FRONT_THRESHOLD: r_front_thr <= i_cfg_data[23:0];
                CFG_RECOVERY_SPEED:  r_speed     <= $signed(i_cfg_data[15:0]);
                CFG_DRIVE_TICKS:     r_drive     <= i_cfg_data[7:0];
                CFG_PAUSE_TICKS:     r_pause     <= i_cfg_data[7:0];
                CFG_TIMEOUT_TICKS:   r_timeout   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // a tick needs a free report slot, other words never wait
    assign w_is_tick = (i_q_op.kind == K_TICK);
    assign w_pop     = i_q_valid && (!w_is_tick || !r_out_valid || o_result.ready);
    assign o_q_pop   = w_pop;

    // new = old + round((65536 - w) * (s*256 - old) / 65536)
    assign w_old      = (i_q_op.kind == K_LEFT) ? r_left_avg : r_right_avg;
    assign w_old_seen = (i_q_op.kind == K_LEFT) ? r_left_seen : r_right_seen;
    assign w_new_wt   = 17'h10000 - {1'b0, r_decay};
    assign w_diff     = $signed({1'b0, i_q_op.sample, 8'h00}) - $signed({1'b0, w_old});
    assign w_prod     = w_diff * $signed({1'b0, w_new_wt});
    assign w_round    = w_prod + 43'sd32768;
    assign w_smooth   = w_old_seen ? (w_old + w_round[39:16]) : {i_q_op.sample, 8'h00};

    assign w_inc_e   = sat_inc8(r_elapsed);
    assign w_age_inc = sat_inc8(r_age);
    assign w_both    = r_left_seen && r_right_seen;
    assign w_front   = w_both && (r_right_avg > r_front_thr);
    assign w_back    = w_both && !w_front && (r_left_avg < r_back_thr);
    assign w_hit     = w_front || w_back;
    assign w_stale   = (w_age_inc > r_timeout);

    // next state
    always_comb begin
        w_drive_cont  = 1'b0;
        w_pause_start = 1'b0;
        w_pause_cont  = 1'b0;
        unique case (r_phase)
            PH_DRIVE: begin
                w_drive_cont  = (w_inc_e < r_drive);
                w_pause_start = !w_drive_cont && (r_pause != 8'd0);
            end
            PH_PAUSE: begin
                w_pause_cont = (w_inc_e < r_pause);
            end
            default: ;
        endcase
        w_busy = w_drive_cont || w_pause_start || w_pause_cont;

        if (w_drive_cont) begin
            w_tick_phase = PH_DRIVE;
        end else if (w_pause_start || w_pause_cont) begin
            w_tick_phase = PH_PAUSE;
        end else if (w_hit) begin
            w_tick_phase = PH_DRIVE;
        end else begin
            w_tick_phase = PH_IDLE;
        end

        n_left_avg   = r_left_avg;
        n_right_avg  = r_right_avg;
        n_left_seen  = r_left_seen;
        n_right_seen = r_right_seen;
        n_phase      = r_phase;
        n_backward   = r_backward;
        n_elapsed    = r_elapsed;
        n_held_lin   = r_held_lin;
        n_held_ang   = r_held_ang;
        n_age        = r_age;

        if (w_pop) begin
            unique case (i_q_op.kind)
                K_LEFT: begin
                    n_left_avg  = w_smooth;
                    n_left_seen = 1'b1;
                end
                K_RIGHT: begin
                    n_right_avg  = w_smooth;
                    n_right_seen = 1'b1;
                end
                K_USER: begin
                    n_held_lin = i_q_op.user_linear;
                    n_held_ang = i_q_op.user_angular;
                    n_age      = 8'd0;
                end
                default: begin
                    n_age   = w_age_inc;
                    n_phase = w_tick_phase;
                    if (w_drive_cont || w_pause_cont) begin
                        n_elapsed = w_inc_e;
                    end else if (w_pause_start) begin
                        n_elapsed = 8'd0;
                    end else if (w_hit) begin
                        n_elapsed  = 8'd0;
                        n_backward = w_front;
                    end else if (w_stale) begin
                        n_held_lin = '0;
                        n_held_ang = '0;
                    end
                end
            endcase
        end
    end

    // report values
    always_comb begin
        w_pass    = !w_busy && !w_hit && !w_stale;
        w_rec_lin = r_backward ? ((r_speed == SPEED_MIN) ? SPEED_MAX : -r_speed) : r_speed;
        if (w_drive_cont) begin
            w_lin = w_rec_lin;
        end else if (w_pass) begin
            w_lin = r_held_lin;
        end else begin
            w_lin = '0;
        end
        w_ang = w_pass ? r_held_ang : 16'sd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_avg   <= '0;
            r_right_avg  <= '0;
            r_left_seen  <= 1'b0;
            r_right_seen <= 1'b0;
            r_phase      <= PH_IDLE;
            r_backward   <= 1'b0;
            r_elapsed    <= '0;
            r_held_lin   <= '0;
            r_held_ang   <= '0;
            r_age        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_left_avg   <= n_left_avg;
            r_right_avg  <= n_right_avg;
            r_left_seen  <= n_left_seen;
            r_right_seen <= n_right_seen;
            r_phase      <= n_phase;
            r_backward   <= n_backward;
            r_elapsed    <= n_elapsed;
            r_held_lin   <= n_held_lin;
            r_held_ang   <= n_held_ang;
            r_age        <= n_age;
            if (w_pop && w_is_tick) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && w_is_tick) begin
            r_out_avg_l   <= r_left_avg;
            r_out_avg_r   <= r_right_avg;
            r_out_seen_l  <= r_left_seen;
            r_out_seen_r  <= r_right_seen;
            r_out_checked <= !w_busy;
            r_out_front   <= !w_busy && w_front;
            r_out_back    <= !w_busy && w_back;
            r_out_lin     <= w_lin;
            r_out_ang     <= w_ang;
            r_out_recov   <= (w_tick_phase != PH_IDLE);
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.average_left     = r_out_avg_l;
    assign o_result.average_right    = r_out_avg_r;
    assign o_result.left_seen        = r_out_seen_l;
    assign o_result.right_seen       = r_out_seen_r;
    assign o_result.hit_report_valid = r_out_checked;
    assign o_result.front_bump       = r_out_front;
    assign o_result.back_bump        = r_out_back;
    assign o_result.safe_linear      = r_out_lin;
    assign o_result.safe_angular     = r_out_ang;
    assign o_result.recovering       = r_out_recov;

endmodule

>>> rtl/bumper_safety_governor.sv
// bumper safety governor top level: input queue front end and processing back end
// depends on bsg_pkg, bsg_in_if, bsg_out_if, bsg_front and bsg_back
// an accepted tick is written to the queue, then popped into the report register that drives its report
// throughput: one word per cycle while reports are taken, set by the back end and its report register
// a blocked report holds a tick at the queue head; the queue takes up to QUEUE_DEPTH words
// reset: synchronous, clears queue, averages, recovery state, held user velocity and loads register defaults

module bumper_safety_governor #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    bsg_in_if.sink                           i_item,
    bsg_out_if.source                        o_result,
    input  logic                             i_cfg_we,
    input  logic [bsg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bsg_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bsg_pkg::*;

    logic w_q_valid;
    t_op  w_q_op;
    logic w_q_pop;

    bsg_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .o_q_valid (w_q_valid),
        .o_q_op    (w_q_op),
        .i_q_pop   (w_q_pop)
    );

    bsg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_op      (w_q_op),
        .o_q_pop     (w_q_pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (o_result)
    );

endmodule

>>> rtl/bsg_checker.sv
// port-level checks on the report channel of the bumper safety governor
// depends on bumper_safety_governor, attached through bind

module bsg_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               i_ready,
    input logic               i_checked,
    input logic               i_front,
    input logic               i_back,
    input logic               i_left_seen,
    input logic               i_right_seen,
    input logic               i_recovering,
    input logic signed [15:0] i_linear
);

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("report dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_linear) && $stable(i_recovering))
        else $error("report changed while stalled");

    a_unchecked_recovers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_checked |-> i_recovering && !i_front && !i_back)
        else $error("hit flags or idle state without a hit check");

    a_hit_starts_recovery: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_front || i_back) |-> i_recovering && i_left_seen && i_right_seen
            && !(i_front && i_back) && (i_linear == 16'sd0))
        else $error("inconsistent hit report");

endmodule

bind bumper_safety_governor bsg_checker u_bsg_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_result.valid),
    .i_ready      (o_result.ready),
    .i_checked    (o_result.hit_report_valid),
    .i_front      (o_result.front_bump),
    .i_back       (o_result.back_bump),
    .i_left_seen  (o_result.left_seen),
    .i_right_seen (o_result.right_seen),
    .i_recovering (o_result.recovering),
    .i_linear     (o_result.safe_linear)
);

>>> verif/bsg_tb_pkg.sv
// scoreboard for the bumper safety governor testbench: report prediction and checking
// depends on bsg_pkg

package bsg_tb_pkg;

    import bsg_pkg::*;

    typedef struct packed {
        logic [23:0]        average_left;
        logic [23:0]        average_right;
        logic               left_seen;
        logic               right_seen;
        logic               hit_report_valid;
        logic               front_bump;
        logic               back_bump;
        logic signed [15:0] safe_linear;
        logic signed [15:0] safe_angular;
        logic               recovering;
    } t_report;

    class governor_scoreboard;
        logic [15:0]        weight;
        logic [23:0]        back_lvl;
        logic [23:0]        front_lvl;
        logic signed [15:0] speed;
        logic [7:0]         drive_len;
        logic [7:0]         pause_len;
        logic [7:0]         timeout_len;

        logic [23:0]        avg_l;
        logic [23:0]        avg_r;
        bit                 seen_l;
        bit                 seen_r;
        t_phase             phase;
        bit                 backward;
        logic [7:0]         elapsed;
        logic signed [15:0] hold_lin;
        logic signed [15:0] hold_ang;
        logic [7:0]         age;

        t_report            expected_reports[$];
        int                 errors;
        int                 reports_checked;
        int                 words_noted;

        function new();
            weight      = RST_DECAY_WEIGHT;
            back_lvl    = RST_BACK_THRESHOLD;
            front_lvl   = RST_FRONT_THRESHOLD;
            speed       = RST_RECOVERY_SPEED;
            drive_len   = RST_DRIVE_TICKS;
            pause_len   = RST_PAUSE_TICKS;
            timeout_len = RST_TIMEOUT_TICKS;
            avg_l       = '0;
            avg_r       = '0;
            seen_l      = 1'b0;
            seen_r      = 1'b0;
            phase       = PH_IDLE;
            backward    = 1'b0;
            elapsed     = '0;
            hold_lin    = '0;
            hold_ang    = '0;
            age         = '0;
            errors          = 0;
            reports_checked = 0;
            words_noted     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DECAY_WEIGHT:    weight      = data[15:0];
                CFG_BACK_THRESHOLD:  back_lvl    = data[23:0];
                CFG_FRONT_THRESHOLD: front_lvl   = data[23:0];
                CFG_RECOVERY_SPEED:  speed       = data[15:0];
                CFG_DRIVE_TICKS:     drive_len   = data[7:0];
                CFG_PAUSE_TICKS:     pause_len   = data[7:0];
                CFG_TIMEOUT_TICKS:   timeout_len = data[7:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] bump8(logic [7:0] v);
            return (v == 8'hFF) ? v : v + 8'd1;
        endfunction

        function logic [23:0] smooth(logic [23:0] old, logic [15:0] s);
            logic [63:0] acc;
            acc = 64'(weight) * 64'(old)
                + (64'd65536 - 64'(weight)) * 64'({s, 8'h00}) + 64'd32768;
            return acc[39:16];
        endfunction

        function void note_word(t_op w);
            t_report     r;
            logic [7:0]  e;
            bit          done;
            words_noted++;
            if (w.kind == K_LEFT) begin
                avg_l  = seen_l ? smooth(avg_l, w.sample) : {w.sample, 8'h00};
                seen_l = 1'b1;
            end else if (w.kind == K_RIGHT) begin
                avg_r  = seen_r ? smooth(avg_r, w.sample) : {w.sample, 8'h00};
                seen_r = 1'b1;
            end else if (w.kind == K_USER) begin
                hold_lin = w.user_linear;
                hold_ang = w.user_angular;
                age      = '0;
            end else begin
                r    = '0;
                done = 1'b0;
                age  = bump8(age);
                if (phase == PH_DRIVE) begin
                    e = bump8(elapsed);
                    if (e < drive_len) begin
                        elapsed = e;
                        if (backward)
                            r.safe_linear = (speed == SPEED_MIN) ? SPEED_MAX : -speed;
                        else
                            r.safe_linear = speed;
                        done = 1'b1;
                    end else if (pause_len != 8'd0) begin
                        phase   = PH_PAUSE;
                        elapsed = '0;
                        done    = 1'b1;
                    end else begin
                        phase = PH_IDLE;
                    end
                end else if (phase == PH_PAUSE) begin
                    e = bump8(elapsed);
                    if (e < pause_len) begin
                        elapsed = e;
                        done    = 1'b1;
                    end else begin
                        phase = PH_IDLE;
                    end
                end
                if (!done) begin
                    r.hit_report_valid = 1'b1;
                    if (seen_l && seen_r) begin
                        r.front_bump = avg_r > front_lvl;
                        r.back_bump  = !r.front_bump && (avg_l < back_lvl);
                    end
                    if (r.front_bump || r.back_bump) begin
                        phase    = PH_DRIVE;
                        backward = r.front_bump;
                        elapsed  = '0;
                    end else begin
                        if (age > timeout_len) begin
                            hold_lin = '0;
                            hold_ang = '0;
                        end
                        r.safe_linear  = hold_lin;
                        r.safe_angular = hold_ang;
                    end
                end
                r.average_left  = avg_l;
                r.average_right = avg_r;
                r.left_seen     = seen_l;
                r.right_seen    = seen_r;
                r.recovering    = (phase != PH_IDLE);
                expected_reports.push_back(r);
            end
        endfunction

        function void field(string name, logic [23:0] want, logic [23:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_report(t_report got);
            t_report want;
            if (expected_reports.size() == 0) begin
                $error("report word arrived with none expected");
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            reports_checked++;
            field("average_left", want.average_left, got.average_left);
            field("average_right", want.average_right, got.average_right);
            field("left_seen", 24'(want.left_seen), 24'(got.left_seen));
            field("right_seen", 24'(want.right_seen), 24'(got.right_seen));
            field("hit_report_valid", 24'(want.hit_report_valid), 24'(got.hit_report_valid));
            field("front_bump", 24'(want.front_bump), 24'(got.front_bump));
            field("back_bump", 24'(want.back_bump), 24'(got.back_bump));
            field("safe_linear", 24'(want.safe_linear), 24'(got.safe_linear));
            field("safe_angular", 24'(want.safe_angular), 24'(got.safe_angular));
            field("recovering", 24'(want.recovering), 24'(got.recovering));
        endfunction
    endclass

endpackage

>>> verif/tb_bumper_safety_governor.sv
// top-level testbench for the bumper safety governor: drives words, ticks and registers
// depends on bsg_pkg, bsg_in_if, bsg_out_if, bsg_tb_pkg and the governor rtl

module tb_bumper_safety_governor;

    timeunit 1ns;
    timeprecision 1ps;

    import bsg_pkg::*;
    import bsg_tb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
    localparam int PHASES      = 12;
    localparam int PHASE_WORDS = 112;
    localparam int SETTLE      = 12;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit calm;
    int settings_count;

    bsg_in_if  item_if();
    bsg_out_if report_if();

    governor_scoreboard book = new();

    bumper_safety_governor dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_item      (item_if),
        .o_result    (report_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [15:0] rnd16();
        return 16'($urandom);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 30);
    endfunction

    function automatic int unsigned pick_field(int unsigned top, int unsigned typ_hi);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        else if (r < 20)
            return top;
        else
            return $urandom_range(0, typ_hi);
    endfunction

    task automatic send_word(t_kind kind, logic [15:0] sample, logic [15:0] lin,
                             logic [15:0] ang);
        t_op         w;
        int unsigned gap;
        w.kind         = kind;
        w.sample       = sample;
        w.user_linear  = lin;
        w.user_angular = ang;
        @(negedge clk);
        item_if.valid        <= 1'b1;
        item_if.command      <= kind;
        item_if.sample       <= sample;
        item_if.user_linear  <= lin;
        item_if.user_angular <= ang;
        do @(posedge clk); while (!item_if.ready);
        book.note_word(w);
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            item_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_tick();
        send_word(K_TICK, rnd16(), rnd16(), rnd16());
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        book.write_reg(idx, data);
    endtask

    // wait until every report is out and the input queue has drained
    task automatic settle();
        int waited;
        waited = 0;
        @(negedge clk);
        item_if.valid <= 1'b0;
        while (book.expected_reports.size() != 0 && waited < 200000) begin
            @(posedge clk);
            waited++;
        end
        if (book.expected_reports.size() != 0) begin
            $error("reports still missing after drain limit");
            book.errors++;
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic load_settings(logic [15:0] weight, logic [23:0] back, logic [23:0] front,
                                 logic [15:0] speed, logic [7:0] drive, logic [7:0] pause,
                                 logic [7:0] timeout);
        logic [23:0] junk;
        junk = 24'($urandom);
        put_reg(CFG_DECAY_WEIGHT, {junk[7:0], weight});
        put_reg(CFG_BACK_THRESHOLD, back);
        put_reg(CFG_FRONT_THRESHOLD, front);
        put_reg(CFG_RECOVERY_SPEED, {junk[23:16], speed});
        put_reg(CFG_DRIVE_TICKS, {junk[15:0], drive});
        put_reg(CFG_PAUSE_TICKS, {junk[23:8], pause});
        put_reg(CFG_TIMEOUT_TICKS, {junk[19:4], timeout});
        if ($urandom_range(0, 2) == 0)
            put_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_count++;
    endtask

    task automatic pick_settings();
        logic [15:0] speed;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15)
            speed = SPEED_MIN;
        else if (r < 30)
            speed = SPEED_MAX;
        else
            speed = rnd16();
        load_settings(16'(pick_field(16'hFFFF, 16'hFFFF)),
                      24'(pick_field(24'hFFFFFF, 24'h040000)),
                      24'(pick_field(24'hFFFFFF, 24'h040000)), speed,
                      8'(pick_field(255, 8)), 8'(pick_field(255, 8)),
                      8'(pick_field(255, 12)));
    endtask

    // samples cluster around the thresholds so that hits come and go
    task automatic random_word();
        int unsigned r;
        int          s;
        logic [15:0] lin;
        logic [15:0] ang;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            send_tick();
        end else if (r < 80) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                s = $urandom_range(0, 1) ? int'(book.front_lvl >> 8) : int'(book.back_lvl >> 8);
                s = s + int'($urandom_range(0, 80)) - 40;
                if (s < 0) s = 0;
                if (s > 65535) s = 65535;
            end else if (r < 75) begin
                s = int'($urandom_range(0, 65535));
            end else begin
                s = $urandom_range(0, 1) ? 65535 : 0;
            end
            send_word($urandom_range(0, 1) ? K_RIGHT : K_LEFT, s[15:0], rnd16(), rnd16());
        end else begin
            lin = rnd16();
            ang = rnd16();
            if ($urandom_range(0, 6) == 0) begin
                lin = $urandom_range(0, 1) ? SPEED_MAX : SPEED_MIN;
                ang = $urandom_range(0, 1) ? SPEED_MAX : SPEED_MIN;
            end
            send_word(K_USER, rnd16(), lin, ang);
        end
    endtask

    initial begin
        int unsigned gap;
        report_if.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                @(negedge clk);
                report_if.ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            report_if.ready <= 1'b1;
            repeat ($urandom_range(0, 6)) @(negedge clk);
        end
    end

    always @(posedge clk) begin
        t_report got;
        if (rst_n && report_if.valid && report_if.ready) begin
            got.average_left     = report_if.average_left;
            got.average_right    = report_if.average_right;
            got.left_seen        = report_if.left_seen;
            got.right_seen       = report_if.right_seen;
            got.hit_report_valid = report_if.hit_report_valid;
            got.front_bump       = report_if.front_bump;
            got.back_bump        = report_if.back_bump;
            got.safe_linear      = report_if.safe_linear;
            got.safe_angular     = report_if.safe_angular;
            got.recovering       = report_if.recovering;
            book.check_report(got);
        end
    end

    initial begin
        #20_000_000;
        $error("run timed out");
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        rst_n                = 1'b0;
        item_if.valid        = 1'b0;
        item_if.command      = '0;
        item_if.sample       = '0;
        item_if.user_linear  = '0;
        item_if.user_angular = '0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        calm                 = 1'b0;
        settings_count       = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset defaults: unseeded tick, pass-through, seeding, front hit and drive
        send_tick();
        send_word(K_USER, rnd16(), SPEED_MAX, SPEED_MIN);
        send_tick();
        send_word(K_LEFT, 16'hFFFF, rnd16(), rnd16());
        send_tick();
        send_word(K_RIGHT, 16'h0000, rnd16(), rnd16());
        send_word(K_RIGHT, 16'hFFFF, rnd16(), rnd16());
        repeat (4) send_tick();

        // front hit with most negative speed, no pause, instant timeout
        settle();
        load_settings(16'hFFFF, 24'hFFFFFF, 24'h000000, SPEED_MIN, 8'd2, 8'd0, 8'd0);
        put_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
        @(negedge clk);
        cfg_we <= 1'b0;
        send_word(K_USER, rnd16(), rnd16(), rnd16());
        send_word(K_LEFT, 16'h0000, rnd16(), rnd16());
        repeat (5) send_tick();

        // back hit, zero drive, new sample replaces average, no timeout
        settle();
        load_settings(16'h0000, 24'hFFFFFF, 24'hFFFFFF, SPEED_MAX, 8'd0, 8'd1, 8'd255);
        send_word(K_USER, rnd16(), SPEED_MIN, SPEED_MAX);
        send_word(K_RIGHT, rnd16(), rnd16(), rnd16());
        repeat (4) send_tick();

        for (int p = 0; p < PHASES; p++) begin
            settle();
            calm = ($urandom_range(0, 3) == 0);
            pick_settings();
            repeat (PHASE_WORDS) random_word();
        end

        settle();
        $display("sent %0d words and checked %0d tick reports", book.words_noted,
                 book.reports_checked);
        $display("register settings loaded: %0d, including min and max values",
                 settings_count);
        if (book.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/bsg_pkg.sv
rtl/bsg_in_if.sv
rtl/bsg_out_if.sv
rtl/bsg_front.sv
rtl/bsg_back.sv
rtl/bumper_safety_governor.sv
rtl/bsg_checker.sv
verif/bsg_tb_pkg.sv
verif/tb_bumper_safety_governor.sv
